// File: rtl/core/sgig_pkg.sv
// Shared types and constants of the stitched grid index generator.
// Beat structs, list phase codes and queue sizing; no dependencies.
`default_nettype none

package sgig_pkg;

    localparam int GRID_SIZE_W = 7;
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 7'd25;
    localparam int MIN_GRID = 3;

    localparam int CORNER_W = 13;
    localparam int MASK_W = 4;

    // Bit positions of the sides in the edge mask.
    localparam logic [1:0] MASK_TOP = 2'd0;
    localparam logic [1:0] MASK_RIGHT = 2'd1;
    localparam logic [1:0] MASK_BOTTOM = 2'd2;
    localparam logic [1:0] MASK_LEFT = 2'd3;

    // Result queue.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Register port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;

    typedef enum logic [2:0] {
        PH_GRID   = 3'd0,
        PH_TOP    = 3'd1,
        PH_BOTTOM = 3'd2,
        PH_RIGHT  = 3'd3,
        PH_LEFT   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef logic [CORNER_W-1:0] t_corner;

    typedef struct packed {
        logic              restart;
        logic [MASK_W-1:0] edge_mask;
    } t_in_beat;

    typedef struct packed {
        t_corner corner_a;
        t_corner corner_b;
        t_corner corner_c;
        logic    last_triangle;
        logic    finished;
    } t_out_beat;

    // Control part of one located triangle, handed from the cursor to the
    // vertex arithmetic.
    typedef struct packed {
        t_phase phase;
        logic   half;
        logic   found;
        logic   last;
    } t_job_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/sgig_cursor.sv
// List cursor: holds the walk position and locates the next triangle and
// the one after it combinationally. Depends on sgig_pkg.
`default_nettype none

module sgig_cursor #(
    parameter int MAX_GRID = 65
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_accept,
    input  sgig_pkg::t_in_beat                    i_in,
    input  wire  [$clog2(MAX_GRID + 1)-1:0]       i_grid,
    output logic                                  o_job_valid,
    output sgig_pkg::t_job_ctrl                   o_job_ctrl,
    output logic [$clog2(MAX_GRID + 1)-1:0]       o_job_row,
    output logic [$clog2(MAX_GRID + 1)-1:0]       o_job_col,
    output logic [$clog2((MAX_GRID - 1) / 2 + 1)-1:0] o_job_step
);

    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int SW = $clog2((MAX_GRID - 1) / 2 + 1);
    localparam int MW = sgig_pkg::MASK_W;
    localparam logic [GW-1:0] ONE = GW'(1);
    localparam logic [GW-1:0] TWO = GW'(2);

    typedef struct packed {
        logic [GW-1:0]    row;
        logic [GW-1:0]    col;
        logic             half;
        sgig_pkg::t_phase phase;
        logic [SW-1:0]    step;
    } t_cursor;

    typedef struct packed {
        logic    found;
        t_cursor emit;
        t_cursor next;
    } t_fetch;

    function automatic logic [1:0] side_bit(input sgig_pkg::t_phase ph);
        logic [1:0] b;
        case (ph)
            sgig_pkg::PH_TOP:    b = sgig_pkg::MASK_TOP;
            sgig_pkg::PH_BOTTOM: b = sgig_pkg::MASK_BOTTOM;
            sgig_pkg::PH_RIGHT:  b = sgig_pkg::MASK_RIGHT;
            default:             b = sgig_pkg::MASK_LEFT;
        endcase
        return b;
    endfunction

    function automatic logic is_dropped(input logic [MW-1:0] m, input logic [GW-1:0] g,
                                        input logic [GW-1:0] x, input logic [GW-1:0] y,
                                        input logic h);
        logic side_half;
        side_half = h ^ y[0];
        return (m[sgig_pkg::MASK_TOP] && !h && (y == '0))
            || (m[sgig_pkg::MASK_BOTTOM] && h && (y == g - TWO))
            || (m[sgig_pkg::MASK_RIGHT] && (x == g - TWO) && side_half)
            || (m[sgig_pkg::MASK_LEFT] && (x == '0) && side_half);
    endfunction

    // Finds the first kept triangle at or after the cursor. Dropped runs
    // inside a row are at most three long, so four positions of the current
    // row and four of the following row cover every case; an empty following
    // row only happens on the smallest grid, where the walk then ends.
    function automatic t_fetch fetch(input t_cursor c, input logic [MW-1:0] m,
                                     input logic [GW-1:0] g);
        t_fetch           f;
        logic [GW-1:0]    g_m1;
        logic [GW:0]      row_len;
        logic [GW+1:0]    pos;
        logic [GW+1:0]    cand;
        logic [GW:0]      cand_n;
        logic [GW-1:0]    row_n;
        logic             grid_hit;
        logic             stitch_hit;
        sgig_pkg::t_phase start_ph;
        sgig_pkg::t_phase ph_i;
        logic [SW-1:0]    start_step;
        logic [SW-1:0]    step_i;
        logic [SW-1:0]    n_stitch;
        f = '{found: 1'b0, emit: c, next: c};
        f.next.phase = sgig_pkg::PH_DONE;
        g_m1 = g - ONE;
        row_len = {g_m1, 1'b0};
        pos = {1'b0, c.col, c.half};
        row_n = c.row + ONE;
        grid_hit = 1'b0;
        stitch_hit = 1'b0;
        start_ph = c.phase;
        start_step = c.step;
        n_stitch = SW'(g_m1 >> 1);

        if (c.phase == sgig_pkg::PH_GRID) begin
            start_ph = sgig_pkg::PH_TOP;
            start_step = '0;
            if (c.row < g_m1) begin
                // Following row first, so the current row overrides it.
                if (row_n < g_m1) begin
                    for (int k = 3; k >= 0; k--) begin
                        cand_n = (GW + 1)'(k);
                        if (!is_dropped(m, g, cand_n[GW:1], row_n, cand_n[0])) begin
                            grid_hit = 1'b1;
                            f.emit.row = row_n;
                            f.emit.col = cand_n[GW:1];
                            f.emit.half = cand_n[0];
                        end
                    end
                end
                for (int k = 3; k >= 0; k--) begin
                    cand = pos + (GW + 2)'(k);
                    if ((cand < {1'b0, row_len})
                            && !is_dropped(m, g, cand[GW:1], c.row, cand[0])) begin
                        grid_hit = 1'b1;
                        f.emit.row = c.row;
                        f.emit.col = cand[GW:1];
                        f.emit.half = cand[0];
                    end
                end
            end
        end

        if (grid_hit) begin
            f.found = 1'b1;
            f.emit.phase = sgig_pkg::PH_GRID;
            f.next = f.emit;
            f.next.col = f.emit.col + GW'(f.emit.half);
            f.next.half = !f.emit.half;
        end else begin
            for (int i = 3; i >= 0; i--) begin
                ph_i = sgig_pkg::t_phase'(3'(i + 1));
                step_i = (ph_i == start_ph) ? start_step : '0;
                if ((ph_i >= start_ph) && m[side_bit(ph_i)] && (step_i < n_stitch)) begin
                    stitch_hit = 1'b1;
                    f.emit.phase = ph_i;
                    f.emit.step = step_i;
                end
            end
            if (stitch_hit) begin
                f.found = 1'b1;
                f.next = f.emit;
                f.next.step = f.emit.step + SW'(1);
            end
        end
        return f;
    endfunction

    t_cursor             r_cur, n_cur, cur_in;
    logic [MW-1:0]       r_mask, n_mask;
    t_fetch              fetch_a, fetch_b;
    logic                r_job_valid;
    sgig_pkg::t_job_ctrl r_job_ctrl, n_job_ctrl;
    logic [GW-1:0]       r_job_row, r_job_col;
    logic [SW-1:0]       r_job_step;

    always_comb begin
        cur_in = r_cur;
        n_mask = r_mask;
        if (i_accept && i_in.restart) begin
            cur_in = '{row: '0, col: '0, half: 1'b0, phase: sgig_pkg::PH_GRID, step: '0};
            n_mask = i_in.edge_mask;
        end
        fetch_a = fetch(cur_in, n_mask, i_grid);
        fetch_b = fetch(fetch_a.next, n_mask, i_grid);
        n_cur = i_accept ? fetch_a.next : r_cur;
    end

    always_comb begin
        n_job_ctrl.phase = fetch_a.emit.phase;
        n_job_ctrl.half = fetch_a.emit.half;
        n_job_ctrl.found = fetch_a.found;
        n_job_ctrl.last = fetch_a.found && !fetch_b.found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '{row: '0, col: '0, half: 1'b0, phase: sgig_pkg::PH_DONE, step: '0};
            r_mask <= '0;
            r_job_valid <= 1'b0;
        end else begin
            r_cur <= n_cur;
            if (i_accept) begin
                r_mask <= n_mask;
            end
            r_job_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_job_ctrl <= n_job_ctrl;
            r_job_row <= fetch_a.emit.row;
            r_job_col <= fetch_a.emit.col;
            r_job_step <= fetch_a.emit.step;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job_ctrl = r_job_ctrl;
    assign o_job_row = r_job_row;
    assign o_job_col = r_job_col;
    assign o_job_step = r_job_step;

    // A finished list stays finished until a restart beat arrives.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.phase == sgig_pkg::PH_DONE) && !(i_accept && i_in.restart)
        |=> (r_cur.phase == sgig_pkg::PH_DONE))
        else $error("cursor left the done phase without a restart");

    // A beat that found no triangle leaves the cursor in the done phase.
    a_miss_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !r_job_ctrl.found |-> (r_cur.phase == sgig_pkg::PH_DONE))
        else $error("finished beat issued while the list continues");

endmodule

`default_nettype wire

// File: rtl/core/sgig_vertex.sv
// Vertex arithmetic: turns a located triangle into three vertex indices,
// one multiply stage followed by the offset adds. Depends on sgig_pkg.
`default_nettype none

module sgig_vertex #(
    parameter int MAX_GRID = 65
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_job_valid,
    input  sgig_pkg::t_job_ctrl                       i_job_ctrl,
    input  wire  [$clog2(MAX_GRID + 1)-1:0]           i_job_row,
    input  wire  [$clog2(MAX_GRID + 1)-1:0]           i_job_col,
    input  wire  [$clog2((MAX_GRID - 1) / 2 + 1)-1:0] i_job_step,
    input  wire  [$clog2(MAX_GRID + 1)-1:0]           i_grid,
    output logic                                      o_beat_valid,
    output sgig_pkg::t_out_beat                       o_beat
);

    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int PW = 2 * GW;
    localparam logic [PW-1:0] ONE = PW'(1);
    localparam logic [PW-1:0] TWO = PW'(2);

    logic [GW-1:0]       oper, k_full;
    logic [PW-1:0]       n_prod, r_prod;
    logic                r_valid;
    sgig_pkg::t_job_ctrl r_ctrl;
    logic [GW-1:0]       r_col, r_k;
    logic [PW-1:0]       g_p, x_p, k_p, r0, r1, xr;
    logic [PW-1:0]       va, vb, vc;

    // The one product each triangle needs: row offset, bottom row base, or
    // the stitch column offset.
    always_comb begin
        k_full = GW'({i_job_step, 1'b0});
        case (i_job_ctrl.phase)
            sgig_pkg::PH_GRID:   oper = i_job_row;
            sgig_pkg::PH_BOTTOM: oper = i_grid - GW'(2);
            sgig_pkg::PH_RIGHT:  oper = k_full;
            sgig_pkg::PH_LEFT:   oper = k_full;
            default:             oper = '0;
        endcase
        n_prod = PW'(oper) * PW'(i_grid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_prod <= n_prod;
            r_ctrl <= i_job_ctrl;
            r_col <= i_job_col;
            r_k <= k_full;
        end
    end

    always_comb begin
        g_p = PW'(i_grid);
        x_p = PW'(r_col);
        k_p = PW'(r_k);
        r0 = r_prod + x_p;
        r1 = r0 + g_p;
        xr = g_p - ONE;
        va = '0;
        vb = '0;
        vc = '0;
        case (r_ctrl.phase)
            sgig_pkg::PH_GRID: begin
                // The cell diagonal flips with the parity of the cell's corner.
                if (!r0[0]) begin
                    if (!r_ctrl.half) begin
                        va = r0;
                        vb = r1 + ONE;
                        vc = r0 + ONE;
                    end else begin
                        va = r1 + ONE;
                        vb = r0;
                        vc = r1;
                    end
                end else begin
                    if (!r_ctrl.half) begin
                        va = r0;
                        vb = r1;
                        vc = r0 + ONE;
                    end else begin
                        va = r0 + ONE;
                        vb = r1;
                        vc = r1 + ONE;
                    end
                end
            end
            sgig_pkg::PH_TOP: begin
                va = k_p;
                vb = k_p + g_p + ONE;
                vc = k_p + TWO;
            end
            sgig_pkg::PH_BOTTOM: begin
                va = r_prod + g_p + k_p;
                vb = r_prod + g_p + k_p + TWO;
                vc = r_prod + k_p + ONE;
            end
            sgig_pkg::PH_RIGHT: begin
                va = xr + r_prod;
                vb = xr - ONE + r_prod + g_p;
                vc = xr + r_prod + g_p + g_p;
            end
            sgig_pkg::PH_LEFT: begin
                va = r_prod;
                vb = r_prod + g_p + g_p;
                vc = r_prod + g_p + ONE;
            end
            default: begin
                va = '0;
                vb = '0;
                vc = '0;
            end
        endcase

        if (r_ctrl.found) begin
            o_beat.corner_a = sgig_pkg::t_corner'(va);
            o_beat.corner_b = sgig_pkg::t_corner'(vb);
            o_beat.corner_c = sgig_pkg::t_corner'(vc);
            o_beat.last_triangle = r_ctrl.last;
            o_beat.finished = 1'b0;
        end else begin
            o_beat.corner_a = '0;
            o_beat.corner_b = '0;
            o_beat.corner_c = '0;
            o_beat.last_triangle = 1'b0;
            o_beat.finished = 1'b1;
        end
    end

    assign o_beat_valid = r_valid;

endmodule

`default_nettype wire

// File: rtl/core/sgig_out_fifo.sv
// Result queue in front of the output channel; absorbs the beats in flight
// while the receiver stalls. Depends on sgig_pkg.
`default_nettype none

module sgig_out_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  sgig_pkg::t_out_beat                i_beat,
    input  wire                                i_take,
    output logic                               o_valid,
    output sgig_pkg::t_out_beat                o_beat,
    output logic [sgig_pkg::OUT_CNT_W-1:0]     o_count
);

    localparam int PTR_W = sgig_pkg::OUT_PTR_W;
    localparam int CNT_W = sgig_pkg::OUT_CNT_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(sgig_pkg::OUT_DEPTH);

    sgig_pkg::t_out_beat r_mem [sgig_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                pop;

    always_comb begin
        pop = (r_count != '0) && i_take;
        n_wr = i_push ? r_wr + PTR_W'(1) : r_wr;
        n_rd = pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_beat = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |-> (r_count != FULL))
        else $error("result queue written while full");

endmodule

`default_nettype wire

// File: rtl/core/stitched_grid_index_generator_unit.sv
// Top level of the stitched grid index generator: register port, input
// admission and the cursor, vertex and result queue stages. Uses sgig_pkg.
//
//   channel | signals                                   | direction
//   in      | i_in_valid, o_in_stall, i_in_data          | restart/mask beats in
//   out     | o_out_valid, i_out_stall, o_out_data       | triangle beats out
//   config  | psel, penable, pwrite, paddr, pwdata, ...  | grid_size register
//
// Every accepted input beat yields exactly one output beat, and a new beat
// can be taken in every cycle while o_in_stall is low. The cursor locates
// the current triangle and looks one triangle ahead (for the last flag)
// combinationally, which is the loop that sets the rate; the vertex multiply
// and adds follow in two stages, behind the cursor's job register.
// Synchronous active-low reset clears the cursor to the finished state and
// loads grid_size with 25; there is no clearing pass.
// The input side stalls only when four beats are in flight (pipeline plus
// result queue), so output stalls never reach o_in_stall combinationally.
`default_nettype none

module stitched_grid_index_generator_unit #(
    parameter int MAX_GRID = 65
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Input channel.
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  sgig_pkg::t_in_beat                   i_in_data,
    // Output channel.
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output sgig_pkg::t_out_beat                  o_out_data,
    // Register port.
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [sgig_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [sgig_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sgig_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int SW = $clog2((MAX_GRID - 1) / 2 + 1);
    localparam int GSW = sgig_pkg::GRID_SIZE_W;
    localparam int CMP_W = (GW > GSW) ? GW : GSW;
    localparam int CNT_W = sgig_pkg::OUT_CNT_W;
    localparam int RIW = sgig_pkg::REG_IDX_W;

    logic [GSW-1:0]           r_grid_size, n_grid_size;
    logic [RIW-1:0]           reg_idx;
    logic                     cfg_write;
    logic [CMP_W-1:0]         gs_w, g_clamp;
    logic [GW-1:0]            eff_grid;
    logic                     accept;
    logic [CNT_W:0]           in_flight;
    logic                     job_valid;
    sgig_pkg::t_job_ctrl      job_ctrl;
    logic [GW-1:0]            job_row, job_col;
    logic [SW-1:0]            job_step;
    logic                     beat_valid;
    sgig_pkg::t_out_beat      beat;
    logic [CNT_W-1:0]         fifo_count;

    // ------------------------------------------------------------------
    // Register port. The only register, grid_size, sits at byte address 0.
    // Writes to any other address are ignored and read back as zero.
    // ------------------------------------------------------------------
    assign reg_idx = paddr[sgig_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_grid_size = r_grid_size;
        if (cfg_write && (reg_idx == sgig_pkg::REG_GRID_SIZE)) begin
            n_grid_size = pwdata[GSW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= sgig_pkg::GRID_SIZE_RESET;
        end else begin
            r_grid_size <= n_grid_size;
        end
    end

    always_comb begin
        case (reg_idx)
            sgig_pkg::REG_GRID_SIZE: prdata = sgig_pkg::APB_DATA_W'(r_grid_size);
            default:                 prdata = '0;
        endcase
    end

    // The working grid size is the register clamped to the supported range
    // and rounded down to an odd value.
    always_comb begin
        gs_w = CMP_W'(r_grid_size);
        if (gs_w < CMP_W'(sgig_pkg::MIN_GRID)) begin
            g_clamp = CMP_W'(sgig_pkg::MIN_GRID);
        end else if (gs_w > CMP_W'(MAX_GRID)) begin
            g_clamp = CMP_W'(MAX_GRID);
        end else begin
            g_clamp = gs_w;
        end
        if (!g_clamp[0]) begin
            g_clamp = g_clamp - CMP_W'(1);
        end
        eff_grid = GW'(g_clamp);
    end

    // ------------------------------------------------------------------
    // Admission: count every beat between the input and the output port so
    // the result queue can never overflow.
    // ------------------------------------------------------------------
    assign in_flight = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(job_valid)
                     + (CNT_W + 1)'(beat_valid);
    assign o_in_stall = (in_flight >= (CNT_W + 1)'(sgig_pkg::OUT_DEPTH));
    assign accept = i_in_valid && !o_in_stall;

    sgig_cursor #(
        .MAX_GRID (MAX_GRID)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in_data),
        .i_grid      (eff_grid),
        .o_job_valid (job_valid),
        .o_job_ctrl  (job_ctrl),
        .o_job_row   (job_row),
        .o_job_col   (job_col),
        .o_job_step  (job_step)
    );

    sgig_vertex #(
        .MAX_GRID (MAX_GRID)
    ) u_vertex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job_ctrl   (job_ctrl),
        .i_job_row    (job_row),
        .i_job_col    (job_col),
        .i_job_step   (job_step),
        .i_grid       (eff_grid),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    sgig_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (beat_valid),
        .i_beat  (beat),
        .i_take  (!i_out_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .o_count (fifo_count)
    );

    // The in-flight count never exceeds the queue depth.
    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= (CNT_W + 1)'(sgig_pkg::OUT_DEPTH))
        else $error("more beats in flight than the result queue holds");

    // Each accepted beat enters the vertex pipeline on the next cycle.
    a_accept_to_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> job_valid)
        else $error("accepted beat did not reach the vertex stage");

endmodule

`default_nettype wire

// File: tb/stitched_grid_index_generator_unit_tb.sv
// Self-checking testbench of stitched_grid_index_generator_unit: random
// request beats, random stalls and grid_size changes, every triangle checked.
// Depends on sgig_pkg and the unit itself; needs no files and no arguments.
`default_nettype none

module stitched_grid_index_generator_unit_tb;

    import sgig_pkg::*;

    localparam int GRID_LIMIT = 65;
    // Result passes the cursor, vertex and queue registers; leave some margin.
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int LONG_HOLD_AT = 300;
    localparam int PLAN_LEN = 16;

    localparam logic [APB_ADDR_W-1:0] GRID_SIZE_ADDR = {REG_GRID_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_GRID_SIZE, 2'b00};

    // Cursor of the triangle list, as the predictor keeps it.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [6:0]        row;
        logic [6:0]        col;
        logic              half;
        t_phase            phase;
        logic [5:0]        step;
    } t_cursor;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_beat o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Predictor state: register copy and list cursor. After reset the list
    // is already finished, so requests without a restart get finished beats.
    logic [GRID_SIZE_W-1:0] grid_size_reg = GRID_SIZE_RESET;
    t_cursor walk = '{mask: '0, row: '0, col: '0, half: 1'b0, phase: PH_DONE, step: '0};

    t_in_beat pending_requests[$];
    t_out_beat expected_triangles[$];

    // Handshake bookkeeping shared by the driving processes.
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int hold_gap = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;
    int idle_cycles = 0;

    int error_count = 0;
    int requests_taken = 0;
    int triangles_checked = 0;
    int lists_closed = 0;
    int finished_beats = 0;
    int restarts_seen = 0;
    int settings_used = 1;

    stitched_grid_index_generator_unit #(
        .MAX_GRID(GRID_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The register is clamped into [MIN_GRID, GRID_LIMIT] and forced odd.
    function automatic int effective_size(logic [GRID_SIZE_W-1:0] raw);
        int g;
        g = raw;
        if (g < MIN_GRID) g = MIN_GRID;
        if (g > GRID_LIMIT) g = GRID_LIMIT;
        if (g % 2 == 0) g = g - 1;
        return g;
    endfunction

    function automatic t_cursor fresh_cursor(logic [MASK_W-1:0] mask);
        t_cursor c;
        c = '{mask: mask, row: '0, col: '0, half: 1'b0, phase: PH_GRID, step: '0};
        return c;
    endfunction

    // Finds the next triangle at or after the cursor and steps past it.
    // Returns 0 once the list is exhausted.
    function automatic bit fetch_triangle(inout t_cursor c, input int g,
                                          output int va, output int vb, output int vc);
        int stitches, x, y, k, r0, r1;
        bit h, drop, side_on;
        stitches = (g - 1) / 2;
        va = 0;
        vb = 0;
        vc = 0;
        while (1) begin
            if (c.phase == PH_GRID) begin
                if (c.row >= g - 1) begin
                    c.phase = PH_TOP;
                    c.step = '0;
                end else if (c.col >= g - 1) begin
                    // Also reached when the grid shrank under a running list.
                    c.col = '0;
                    c.half = 1'b0;
                    c.row = c.row + 1'b1;
                end else begin
                    x = c.col;
                    y = c.row;
                    h = c.half;
                    // Triangles facing a flagged side give way to stitches.
                    drop = (c.mask[MASK_TOP] && !h && y == 0)
                        || (c.mask[MASK_BOTTOM] && h && y == g - 2)
                        || (c.mask[MASK_RIGHT] && x == g - 2 && (h ^ y[0]))
                        || (c.mask[MASK_LEFT] && x == 0 && (h ^ y[0]));
                    if (c.half) begin
                        c.half = 1'b0;
                        c.col = c.col + 1'b1;
                    end else begin
                        c.half = 1'b1;
                    end
                    if (!drop) begin
                        r0 = y * g + x;
                        r1 = r0 + g;
                        // The diagonal flips with the parity of the cell's corner index.
                        if (!r0[0]) begin
                            if (!h) begin
                                va = r0; vb = r1 + 1; vc = r0 + 1;
                            end else begin
                                va = r1 + 1; vb = r0; vc = r1;
                            end
                        end else begin
                            if (!h) begin
                                va = r0; vb = r1; vc = r0 + 1;
                            end else begin
                                va = r0 + 1; vb = r1; vc = r1 + 1;
                            end
                        end
                        return 1'b1;
                    end
                end
            end else if (c.phase >= PH_TOP && c.phase <= PH_LEFT) begin
                case (c.phase)
                    PH_TOP: side_on = c.mask[MASK_TOP];
                    PH_BOTTOM: side_on = c.mask[MASK_BOTTOM];
                    PH_RIGHT: side_on = c.mask[MASK_RIGHT];
                    default: side_on = c.mask[MASK_LEFT];
                endcase
                if (!side_on || c.step >= stitches) begin
                    c.phase = t_phase'(c.phase + 3'd1);
                    c.step = '0;
                end else begin
                    k = 2 * c.step;
                    case (c.phase)
                        PH_TOP: begin
                            va = k; vb = k + g + 1; vc = k + 2;
                        end
                        PH_BOTTOM: begin
                            va = (g - 1) * g + k;
                            vb = (g - 1) * g + k + 2;
                            vc = (g - 2) * g + k + 1;
                        end
                        PH_RIGHT: begin
                            va = g - 1 + k * g;
                            vb = g - 2 + (k + 1) * g;
                            vc = g - 1 + (k + 2) * g;
                        end
                        default: begin
                            va = k * g; vb = (k + 2) * g; vc = 1 + (k + 1) * g;
                        end
                    endcase
                    c.step = c.step + 1'b1;
                    return 1'b1;
                end
            end else begin
                c.phase = PH_DONE;
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    // Advances the predictor cursor by one request beat and returns the
    // triangle beat the unit owes for it.
    function automatic t_out_beat predict_triangle(t_in_beat beat, int g);
        t_out_beat res;
        t_cursor peek;
        int va, vb, vc, pa, pb, pc;
        res = '0;
        if (beat.restart) walk = fresh_cursor(beat.edge_mask);
        if (fetch_triangle(walk, g, va, vb, vc)) begin
            peek = walk;
            res.corner_a = t_corner'(va);
            res.corner_b = t_corner'(vb);
            res.corner_c = t_corner'(vc);
            res.last_triangle = !fetch_triangle(peek, g, pa, pb, pc);
        end else begin
            res.finished = 1'b1;
        end
        return res;
    endfunction

    function automatic int list_length(logic [MASK_W-1:0] mask, int g);
        t_cursor c;
        int n, va, vb, vc;
        c = fresh_cursor(mask);
        n = 0;
        while (fetch_triangle(c, g, va, vb, vc)) n++;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: presents the queued beats at falling edges, with a
    // random gap after every accepted beat unless the phase is quiet.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        logic offer;
        if (i_rst_n) begin
            offer = i_in_valid && !in_took;
            if (i_in_valid && in_took) send_gap = quiet ? 0 : $urandom_range(0, 10);
            if (!offer) begin
                if (send_gap == 0 && pending_requests.size() != 0) begin
                    i_in_data <= pending_requests.pop_front();
                    offer = 1'b1;
                end else if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                end
            end
            i_in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stalls for a random number of cycles after each beat
    // it takes. Once, after a few hundred beats, it holds off for a long
    // stretch so the pipeline and result queue fill and the input stalls.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_stall
        logic stall;
        if (i_rst_n) begin
            if (out_took) hold_gap = quiet ? 0 : $urandom_range(0, 10);
            if (!long_hold_done && triangles_checked >= LONG_HOLD_AT) begin
                long_hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (long_hold_left != 0) begin
                stall = 1'b1;
                long_hold_left = long_hold_left - 1;
            end else if (hold_gap != 0) begin
                stall = 1'b1;
                hold_gap = hold_gap - 1;
            end else begin
                stall = 1'b0;
            end
            i_out_stall <= stall;
        end
    end

    task automatic check_field(input string label, input logic [CORNER_W-1:0] want,
                               input logic [CORNER_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. The output beat is
    // checked before this edge's request is predicted, so a spurious result
    // can never be matched against an expectation queued in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_beats
        t_out_beat want;
        bit moved;
        if (!i_rst_n) begin
            in_took <= 1'b0;
            out_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            out_took <= o_out_valid && !i_out_stall;
            moved = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready);
            if (o_out_valid && !i_out_stall) begin
                if (expected_triangles.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected triangle beat, expected none, got %h",
                             $time, o_out_data);
                end else begin
                    want = expected_triangles.pop_front();
                    check_field("corner_a", want.corner_a, o_out_data.corner_a);
                    check_field("corner_b", want.corner_b, o_out_data.corner_b);
                    check_field("corner_c", want.corner_c, o_out_data.corner_c);
                    check_field("last_triangle", CORNER_W'(want.last_triangle),
                                CORNER_W'(o_out_data.last_triangle));
                    check_field("finished", CORNER_W'(want.finished),
                                CORNER_W'(o_out_data.finished));
                end
                triangles_checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                want = predict_triangle(i_in_data, effective_size(grid_size_reg));
                expected_triangles.push_back(want);
                requests_taken++;
                if (i_in_data.restart) restarts_seen++;
                if (want.last_triangle) lists_closed++;
                if (want.finished) finished_beats++;
            end
            // Only stretches without any accepted beat or register access count toward a hang.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles, %0d triangles outstanding",
                         $time, idle_cycles, expected_triangles.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_request(input bit restart, input logic [MASK_W-1:0] mask);
        t_in_beat beat;
        beat.restart = restart;
        beat.edge_mask = mask;
        pending_requests.push_back(beat);
    endtask

    // Restart with the given mask, then the given count of plain requests.
    // The mask of plain requests is random since the unit ignores it.
    task automatic queue_list(input logic [MASK_W-1:0] mask, input int count);
        push_request(1'b1, mask);
        repeat (count) push_request(1'b0, MASK_W'($urandom));
    endtask

    // Waits until every request was taken and answered, then lets the
    // pipeline run empty before the register is touched.
    task automatic settle();
        while (pending_requests.size() != 0 || i_in_valid || expected_triangles.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_access(input bit write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Writes grid_size with random junk above its seven bits, updates the
    // predictor's copy and reads the register back.
    task automatic write_grid_size(input logic [GRID_SIZE_W-1:0] value);
        logic [APB_DATA_W-1:0] data, rdata;
        data = $urandom;
        data[GRID_SIZE_W-1:0] = value;
        reg_access(1'b1, GRID_SIZE_ADDR, data, rdata);
        grid_size_reg = value;
        settings_used++;
        reg_access(1'b0, GRID_SIZE_ADDR, '0, rdata);
        if (rdata !== APB_DATA_W'(value)) begin
            error_count++;
            $display("%0t: grid_size read back expected %0d, got %0d", $time, value, rdata);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    // Grid sizes in order: both extremes, values below the minimum, even
    // values, values above the limit, and a few mid sizes.
    int size_plan [0:PLAN_LEN-1] = '{3, 5, 7, 0, 2, 4, 9, 127, 1, 6, 65, 11, 66, 5, 13, 3};

    initial begin : run_test
        logic [APB_DATA_W-1:0] rdata;
        logic [MASK_W-1:0] mask;
        int g, budget, used, len, pick, n;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset size of 25. Requests before any
        // restart must come back finished with zero corners.
        push_request(1'b0, 4'hF);
        push_request(1'b0, 4'h0);
        queue_list(4'hF, 2);
        queue_list(4'h0, 1);
        settle();

        // A write to the unused register index must leave grid_size alone.
        reg_access(1'b1, SPARE_ADDR, $urandom, rdata);

        for (int p = 0; p < PLAN_LEN; p++) begin
            write_grid_size(GRID_SIZE_W'(size_plan[p]));
            g = effective_size(grid_size_reg);
            quiet = (p % 4 == 3);

            // The list left open by the previous phase goes on under the new
            // size, so the cursor may sit outside the grid for a moment.
            n = $urandom_range(1, 2);
            repeat (n) push_request(1'b0, MASK_W'($urandom));

            if (p == 0) begin
                // Smallest grid: all sides (every grid triangle dropped),
                // opposite pairs, and no stitching, each walked to the end.
                queue_list(4'hF, list_length(4'hF, g) + 1);
                queue_list(4'h5, list_length(4'h5, g) + 1);
                queue_list(4'hA, list_length(4'hA, g) + 1);
                queue_list(4'h0, list_length(4'h0, g) + 1);
            end

            // Large grids only get the start of a list; small and mid sizes
            // are walked to the end many times.
            budget = (g <= 7) ? 40 : (g <= 13) ? 130 : 25;
            used = 0;
            while (used < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 82) begin
                    mask = MASK_W'($urandom);
                    len = list_length(mask, g) + $urandom_range(0, 2);
                    // Now and then a list is cut short by the next restart.
                    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len);
                    if (len > budget - used) len = budget - used;
                    queue_list(mask, len);
                    used += len + 1;
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_request($urandom_range(0, 3) == 0, MASK_W'($urandom));
                    used += n;
                end
            end
            settle();
        end

        $display("Run took %0d request beats (%0d restarts) under %0d grid_size settings.",
                 requests_taken, restarts_seen, settings_used);
        $display("Checked %0d triangle beats: %0d lists walked to their end, %0d finished.",
                 triangles_checked, lists_closed, finished_beats);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/sgig_pkg.sv
rtl/core/sgig_cursor.sv
rtl/core/sgig_vertex.sv
rtl/core/sgig_out_fifo.sv
rtl/core/stitched_grid_index_generator_unit.sv
tb/stitched_grid_index_generator_unit_tb.sv
